// ===== hw/rtl/hsfs_pkg.sv =====
package hsfs_pkg;

	// Default number of devices carried in one frame
	localparam int DEVICE_COUNT_DEF = 5;

	// Header bytes plus three discrete bytes precede the data pairs
	localparam int DISCRETE_END = 5;

	localparam int BYTE_W   = 8;
	localparam int ID_W     = 3;
	localparam int COUNT_W  = 32;
	localparam int CFG_IDX_W = 1;

	// Output tdata: device_id, value_high, value_low, frame_count, padded to bytes
	localparam int OUT_FIELDS_W = ID_W + 2 * BYTE_W + COUNT_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_HDR  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_HDR = 1'b1;

	localparam logic [BYTE_W-1:0] FIRST_HDR_RST  = 8'hA5;
	localparam logic [BYTE_W-1:0] SECOND_HDR_RST = 8'h99;

	// Commands from controller to datapath
	typedef struct packed {
		logic take;     // input byte accepted this cycle
		logic advance;  // load next device result into the output register
	} hsfs_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic at_end;    // frame position is at the last byte
		logic dev_last;  // device counter is at the final device
		logic out_free;  // output register can take a result this cycle
	} hsfs_stat_t;

endpackage

// ===== hw/rtl/hsfs_ctrl.sv =====
module hsfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  hsfs_pkg::hsfs_stat_t stat,
	output hsfs_pkg::hsfs_cmd_t  cmd
);
	import hsfs_pkg::*;

	localparam logic [1:0] ST_RECV = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Accept bytes only while receiving
	assign s_tready    = (state_q == ST_RECV);
	assign cmd.take    = s_tready && s_tvalid;
	assign cmd.advance = (state_q == ST_EMIT) && stat.out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RECV: begin
				if (cmd.take && stat.at_end) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.advance && stat.dev_last) begin
					state_d = ST_RECV;
				end
			end
			default: begin
				state_d = ST_RECV;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/hsfs_datapath.sv =====
module hsfs_datapath #(
	parameter int DEVICE_COUNT = hsfs_pkg::DEVICE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hsfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsfs_pkg::BYTE_W-1:0]     cfg_data,
	input  logic [hsfs_pkg::BYTE_W-1:0]     rx_byte,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [hsfs_pkg::ID_W-1:0]       device_id,
	output logic [hsfs_pkg::BYTE_W-1:0]     value_high,
	output logic [hsfs_pkg::BYTE_W-1:0]     value_low,
	output logic [hsfs_pkg::COUNT_W-1:0]    frame_count,
	output logic                            last_of_frame,
	input  hsfs_pkg::hsfs_cmd_t             cmd,
	output hsfs_pkg::hsfs_stat_t            stat
);
	import hsfs_pkg::*;

	localparam int FRAME_LEN = DISCRETE_END + 2 * DEVICE_COUNT;
	localparam int PW        = $clog2(FRAME_LEN);
	localparam int DW        = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

	localparam logic [PW-1:0] POS_HDR2    = PW'(1);
	localparam logic [PW-1:0] POS_DATA    = PW'(DISCRETE_END);
	localparam logic [PW-1:0] POS_LAST    = PW'(FRAME_LEN - 1);
	localparam logic [PW-1:0] POS_LIMIT   = PW'(FRAME_LEN);
	localparam logic [DW-1:0] DEV_LAST    = DW'(DEVICE_COUNT - 1);

	logic [BYTE_W-1:0]  first_hdr_q;
	logic [BYTE_W-1:0]  second_hdr_q;
	logic [PW-1:0]      pos_q;
	logic [COUNT_W-1:0] frames_q;
	logic [DW-1:0]      dev_q;
	logic               out_valid_q;

	logic [BYTE_W-1:0]   hi_q;
	logic [2*BYTE_W-1:0] mem [DEVICE_COUNT];
	logic [2*BYTE_W-1:0] rd_q;

	logic [ID_W-1:0]    id_q;
	logic [BYTE_W-1:0]  vhi_q;
	logic [BYTE_W-1:0]  vlo_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               last_q;

	logic [PW-1:0] pos_off;
	logic [DW-1:0] row_idx;
	logic [DW-1:0] rd_addr;
	logic          in_data;

	assign stat.at_end   = (pos_q == POS_LAST);
	assign stat.dev_last = (dev_q == DEV_LAST);
	assign stat.out_free = !out_valid_q || m_tready;

	// Data pair slot of the current byte
	assign pos_off = pos_q - POS_DATA;
	assign row_idx = DW'(pos_off >> 1);
	assign in_data = (pos_q >= POS_DATA) && (pos_q < POS_LIMIT);

	// Prefetch the row for the next device when a result is loaded
	assign rd_addr = (cmd.advance && !stat.dev_last) ? (dev_q + DW'(1)) : dev_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_hdr_q  <= FIRST_HDR_RST;
			second_hdr_q <= SECOND_HDR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST_HDR:  first_hdr_q  <= cfg_data;
				REG_SECOND_HDR: second_hdr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame position and frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			frames_q <= '0;
		end else if (cmd.take) begin
			if (pos_q == '0) begin
				if (rx_byte == first_hdr_q) begin
					pos_q <= POS_HDR2;
				end
			end else if (pos_q == POS_HDR2) begin
				pos_q <= (rx_byte == second_hdr_q) ? PW'(2) : '0;
			end else if (pos_q >= POS_LIMIT) begin
				pos_q <= '0;
			end else if (pos_q == POS_LAST) begin
				pos_q    <= '0;
				frames_q <= frames_q + COUNT_W'(1);
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	// Hold the high byte, write the whole pair with the low byte
	always_ff @(posedge clk) begin
		if (cmd.take && in_data) begin
			if (!pos_off[0]) begin
				hi_q <= rx_byte;
			end else begin
				mem[row_idx] <= {hi_q, rx_byte};
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	// Device counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.advance) begin
				dev_q       <= stat.dev_last ? '0 : (dev_q + DW'(1));
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			id_q   <= ID_W'(int'(dev_q) + 1);
			vhi_q  <= rd_q[2*BYTE_W-1:BYTE_W];
			vlo_q  <= rd_q[BYTE_W-1:0];
			cnt_q  <= frames_q;
			last_q <= stat.dev_last;
		end
	end

	assign m_tvalid      = out_valid_q;
	assign device_id     = id_q;
	assign value_high    = vhi_q;
	assign value_low     = vlo_q;
	assign frame_count   = cnt_q;
	assign last_of_frame = last_q;

endmodule

// ===== hw/rtl/header_sync_frame_splitter.sv =====
// Header-synchronized frame splitter.
// Input stream: one received byte per transaction on s_tdata. The block hunts
// for a two-byte header, then collects a frame of 5 + 2*DEVICE_COUNT bytes.
// Output stream: at each frame end, DEVICE_COUNT transactions in device order,
// each carrying the device number, its two data bytes and the frame count;
// m_tlast marks the final device of the frame.
// Configuration: cfg_we/cfg_index/cfg_data write the two header bytes; write
// them only while no frame results are pending.
// Throughput: non-final bytes are accepted back to back. After the frame-end
// byte, input ready stays low while the controller passes through a prepare
// state, which reads the first pair from the payload memory, and an emit state,
// which loads one result per cycle out of its registered read port while the
// output register is free, until the final result is loaded.
// Stall: a result waits in the output register while m_tready is low; the
// emission pauses there. Once the final result is loaded, new bytes are
// accepted while it still waits to be taken.
// Reset: position, frame count and output valid clear; header registers
// return to 0xA5 and 0x99. Payload memory is not cleared.
module header_sync_frame_splitter #(
	parameter int DEVICE_COUNT = hsfs_pkg::DEVICE_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hsfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hsfs_pkg::BYTE_W-1:0]        cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [hsfs_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [2:0] device_id, [10:3] value_high, [18:11] value_low,
	// [50:19] frame_count, [55:51] zero
	output logic [hsfs_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                               m_tlast    // last_of_frame
);
	import hsfs_pkg::*;

	hsfs_cmd_t  cmd;
	hsfs_stat_t stat;

	logic [ID_W-1:0]    device_id;
	logic [BYTE_W-1:0]  value_high;
	logic [BYTE_W-1:0]  value_low;
	logic [COUNT_W-1:0] frame_count;

	hsfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hsfs_datapath #(
		.DEVICE_COUNT (DEVICE_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (s_tdata),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.device_id     (device_id),
		.value_high    (value_high),
		.value_low     (value_low),
		.frame_count   (frame_count),
		.last_of_frame (m_tlast),
		.cmd           (cmd),
		.stat          (stat)
	);

	// Pack output fields, lowest first
	assign m_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), frame_count, value_low, value_high,
		device_id};

endmodule

// ===== hw/rtl/hsfs_checker.sv =====
module hsfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// No byte accepted while a frame's results are still being emitted
	a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready during frame emission");

	// Taking a non-final result loads the next one at once
	a_emit_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("emission stopped before final result");

	// Frame count is the same across results of one frame
	a_count_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			(!m_tvalid || m_tdata[50:19] == $past(m_tdata[50:19])))
		else $error("frame count changed within a frame");

endmodule

bind header_sync_frame_splitter hsfs_checker u_hsfs_checker (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;
	import hsfs_pkg::*;

	localparam int NDEV      = DEVICE_COUNT_DEF;
	localparam int FRAME_LEN = DISCRETE_END + 2 * NDEV;
	localparam int PHASE_ITEMS = 56;
	localparam int MAX_GAP   = 16;
	localparam int SETTLE    = NDEV + 4;
	localparam int NO_CHECK  = -1;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BYTE_W-1:0]  hi;
		logic [BYTE_W-1:0]  lo;
		logic [COUNT_W-1:0] count;
		logic               last;
	} dev_result_t;

	// One directed row: a register write or a received byte
	typedef struct {
		logic                 is_write;
		logic [CFG_IDX_W-1:0] idx;
		logic [BYTE_W-1:0]    value;
		int                   typed_results;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [BYTE_W-1:0]     cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata;    // [7:0] rx_byte
	logic                  m_tvalid;
	logic                  m_tready;
	// [2:0] device_id, [10:3] value_high, [18:11] value_low,
	// [50:19] frame_count, [55:51] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;    // last_of_frame

	// Deframer state mirrored by the testbench
	logic [BYTE_W-1:0]  hdr_first;
	logic [BYTE_W-1:0]  hdr_second;
	int                 hunt_pos;
	logic [BYTE_W-1:0]  payload [2*NDEV];
	logic [COUNT_W-1:0] frames_done;
	dev_result_t        pending_devices [$];

	int mismatches = 0;
	int send_idle_pct = 0;
	int sink_stall_pct = 0;

	header_sync_frame_splitter #(.DEVICE_COUNT(NDEV)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Advance the frame tracker by one accepted byte; queue device results at frame end
	function automatic int frame_step(input logic [BYTE_W-1:0] b);
		dev_result_t r;
		int n;
		n = 0;
		if (hunt_pos == 0) begin
			if (b == hdr_first)
				hunt_pos = 1;
		end else if (hunt_pos == 1) begin
			hunt_pos = (b == hdr_second) ? 2 : 0;
		end else begin
			if (hunt_pos >= DISCRETE_END)
				payload[hunt_pos - DISCRETE_END] = b;
			hunt_pos++;
			if (hunt_pos == FRAME_LEN) begin
				hunt_pos = 0;
				frames_done = frames_done + COUNT_W'(1);
				for (int d = 0; d < NDEV; d++) begin
					r.id    = ID_W'(d + 1);
					r.hi    = payload[2*d];
					r.lo    = payload[2*d + 1];
					r.count = frames_done;
					r.last  = (d == NDEV - 1);
					pending_devices.push_back(r);
				end
				n = NDEV;
			end
		end
		return n;
	endfunction

	// Present one byte, hold it until the transaction completes
	task automatic send_byte(input logic [BYTE_W-1:0] b, output int n);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		do @(posedge clk); while (!s_tready);
		n = frame_step(b);
		@(negedge clk);
	endtask

	// Stop sending and let every pending device result drain
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (pending_devices.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		wait_idle();
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_FIRST_HDR)
			hdr_first = val;
		else
			hdr_second = val;
	endtask

	// Random receiver stall
	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= sink_stall_pct);
	end

	// Compare each device result with the oldest one pending
	always @(posedge clk) begin
		dev_result_t want;
		logic [ID_W-1:0]    got_id;
		logic [BYTE_W-1:0]  got_hi;
		logic [BYTE_W-1:0]  got_lo;
		logic [COUNT_W-1:0] got_count;
		if (arst_n && m_tvalid && m_tready) begin
			got_id    = m_tdata[2:0];
			got_hi    = m_tdata[10:3];
			got_lo    = m_tdata[18:11];
			got_count = m_tdata[50:19];
			if (pending_devices.size() == 0) begin
				report_mismatch($sformatf("unexpected result id %0d count %0d",
					got_id, got_count));
			end else begin
				want = pending_devices.pop_front();
				if (got_id !== want.id)
					report_mismatch($sformatf("device_id got %0d want %0d", got_id, want.id));
				if (got_hi !== want.hi)
					report_mismatch($sformatf("value_high got %0h want %0h", got_hi, want.hi));
				if (got_lo !== want.lo)
					report_mismatch($sformatf("value_low got %0h want %0h", got_lo, want.lo));
				if (got_count !== want.count)
					report_mismatch($sformatf("frame_count got %0d want %0d",
						got_count, want.count));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last_of_frame got %0b want %0b",
						m_tlast, want.last));
			end
		end
	end

	// Hard stop if the run hangs
	initial begin
		#6000000;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		stim_row_t directed [] = '{
			// hunting noise, then a first header followed by a wrong second byte
			'{1'b0, REG_FIRST_HDR, 8'h00, 0},
			'{1'b0, REG_FIRST_HDR, 8'hFF, 0},
			'{1'b0, REG_FIRST_HDR, 8'hA5, 0},
			'{1'b0, REG_FIRST_HDR, 8'hA5, 0},
			// a second header byte while hunting is dropped
			'{1'b0, REG_FIRST_HDR, 8'h99, 0},
			// full frame with the reset headers, extreme data bytes
			'{1'b0, REG_FIRST_HDR, 8'hA5, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'h99, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'h00, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'hFF, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'h5A, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'hFF, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'h00, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'h80, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'h01, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'h7F, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'hFE, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'h55, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'hAA, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'h00, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'hFF, NDEV},
			// extreme header values, then a partial frame left open
			'{1'b1, REG_FIRST_HDR, 8'h00, NO_CHECK},
			'{1'b1, REG_SECOND_HDR, 8'hFF, NO_CHECK},
			'{1'b0, REG_FIRST_HDR, 8'h00, 0},
			'{1'b0, REG_FIRST_HDR, 8'h00, 0},
			'{1'b0, REG_FIRST_HDR, 8'h00, 0},
			'{1'b0, REG_FIRST_HDR, 8'hFF, 0}
		};
		logic [BYTE_W-1:0] hdr_plan [8][2];
		logic [BYTE_W-1:0] b;
		int n;
		int phase_items;
		int pick;

		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		arst_n    = 1'b0;

		hdr_first   = FIRST_HDR_RST;
		hdr_second  = SECOND_HDR_RST;
		hunt_pos    = 0;
		frames_done = '0;
		foreach (payload[i])
			payload[i] = '0;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part
		foreach (directed[i]) begin
			if (directed[i].is_write) begin
				write_reg(directed[i].idx, directed[i].value);
			end else begin
				send_byte(directed[i].value, n);
				if (directed[i].typed_results != NO_CHECK && n != directed[i].typed_results)
					report_mismatch($sformatf("row %0d caused %0d results, table says %0d",
						i, n, directed[i].typed_results));
			end
		end

		// Header settings per phase, extremes and equal bytes among them
		hdr_plan = '{'{8'h00, 8'hFF}, '{8'hFF, 8'h00}, '{8'hA5, 8'h99}, '{8'h00, 8'h00},
			'{8'h5A, 8'h5A}, '{8'hFF, 8'hFF}, '{8'h00, 8'h00}, '{8'h00, 8'h00}};
		hdr_plan[3][0] = BYTE_W'($urandom_range(255));
		hdr_plan[3][1] = BYTE_W'($urandom_range(255));
		hdr_plan[6][0] = BYTE_W'($urandom_range(255));
		hdr_plan[6][1] = BYTE_W'($urandom_range(255));
		hdr_plan[7][0] = BYTE_W'($urandom_range(255));
		hdr_plan[7][1] = BYTE_W'($urandom_range(255));

		// Random part: mostly well-formed frames, some noise and broken headers
		for (int p = 0; p < 8; p++) begin
			write_reg(REG_FIRST_HDR, hdr_plan[p][0]);
			write_reg(REG_SECOND_HDR, hdr_plan[p][1]);
			case (p / 2)
				0: begin
					send_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 59;
					sink_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					sink_stall_pct = 59;
				end
				default: begin
					send_idle_pct = 31;
					sink_stall_pct = 31;
				end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					send_byte(hdr_first, n);
					send_byte(hdr_second, n);
					for (int k = 0; k < FRAME_LEN - 2; k++) begin
						send_byte(BYTE_W'($urandom_range(255)), n);
					end
					phase_items += FRAME_LEN;
				end else if (pick < 85) begin
					repeat ($urandom_range(3, 1)) begin
						send_byte(BYTE_W'($urandom_range(255)), n);
						phase_items++;
					end
				end else if (pick < 95) begin
					b = BYTE_W'($urandom_range(255));
					if (b == hdr_second)
						b = b ^ 8'h01;
					send_byte(hdr_first, n);
					send_byte(b, n);
					phase_items += 2;
				end else begin
					// header then a cut-short frame; later bytes fill it
					send_byte(hdr_first, n);
					send_byte(hdr_second, n);
					repeat ($urandom_range(FRAME_LEN - 3)) begin
						send_byte(BYTE_W'($urandom_range(255)), n);
						phase_items++;
					end
					phase_items += 2;
				end
			end
		end

		// Drain and finish
		send_idle_pct = 0;
		sink_stall_pct = 0;
		wait_idle();
		repeat (4 * SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/hsfs_pkg.sv
hw/rtl/hsfs_ctrl.sv
hw/rtl/hsfs_datapath.sv
hw/rtl/header_sync_frame_splitter.sv
hw/rtl/hsfs_checker.sv
tb/sv/tb_top.sv
